/* rtl/cft_pkg.sv */
// Shared types and character codes for the CSV field tokenizer.
package cft_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned KindW = 3;

  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChNl    = 8'h0A;
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChQuote = 8'h22;

  // Parser mode, one-hot.
  typedef enum logic [4:0] {
    MODE_START  = 5'b00001,
    MODE_PLAIN  = 5'b00010,
    MODE_QUOTED = 5'b00100,
    MODE_QSEEN  = 5'b01000,
    MODE_DONE   = 5'b10000
  } mode_e;

  // Result kind as seen on the output tuser.
  typedef enum logic [KindW-1:0] {
    KIND_NONE    = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_END     = 3'd2,
    KIND_LINEEND = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] char_out;
    logic             ended_at_nul;
  } result_t;

endpackage

/* rtl/cft_parser.sv */
// Parser mode register, per-character decode and result register.
module cft_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,        // consume the held character
  input  logic [cft_pkg::CharW-1:0] char_i,
  input  logic                     line_begin_i,
  output cft_pkg::result_t         res_o
);

  cft_pkg::mode_e   mode_q, mode_d, mode_cur;
  cft_pkg::result_t res_q, res_d;
  logic             is_term;

  always_comb begin
    is_term  = (char_i == cft_pkg::ChComma) || (char_i == cft_pkg::ChNl) ||
               (char_i == cft_pkg::ChNul);
    mode_cur = line_begin_i ? cft_pkg::MODE_START : mode_q;
    mode_d   = mode_cur;
    res_d    = '{kind: cft_pkg::KIND_NONE, char_out: '0, ended_at_nul: 1'b0};

    case (mode_cur)
      cft_pkg::MODE_START: begin
        if (char_i == cft_pkg::ChNul) begin
          mode_d     = cft_pkg::MODE_DONE;
          res_d.kind = cft_pkg::KIND_LINEEND;
        end else if (char_i == cft_pkg::ChQuote) begin
          mode_d = cft_pkg::MODE_QUOTED;
        end else if (is_term) begin
          // empty field, stay at field start
          res_d.kind = cft_pkg::KIND_END;
        end else begin
          mode_d         = cft_pkg::MODE_PLAIN;
          res_d.kind     = cft_pkg::KIND_DATA;
          res_d.char_out = char_i;
        end
      end
      cft_pkg::MODE_PLAIN: begin
        if (is_term) begin
          res_d.kind = cft_pkg::KIND_END;
          if (char_i == cft_pkg::ChNul) begin
            mode_d             = cft_pkg::MODE_DONE;
            res_d.ended_at_nul = 1'b1;
          end else begin
            mode_d = cft_pkg::MODE_START;
          end
        end else if (char_i == cft_pkg::ChQuote) begin
          mode_d     = cft_pkg::MODE_DONE;
          res_d.kind = cft_pkg::KIND_ERROR;
        end else begin
          res_d.kind     = cft_pkg::KIND_DATA;
          res_d.char_out = char_i;
        end
      end
      cft_pkg::MODE_QUOTED: begin
        if (char_i == cft_pkg::ChQuote) begin
          mode_d = cft_pkg::MODE_QSEEN;
        end else if (char_i == cft_pkg::ChNul) begin
          mode_d     = cft_pkg::MODE_DONE;
          res_d.kind = cft_pkg::KIND_ERROR;
        end else begin
          res_d.kind     = cft_pkg::KIND_DATA;
          res_d.char_out = char_i;
        end
      end
      cft_pkg::MODE_QSEEN: begin
        if (char_i == cft_pkg::ChQuote) begin
          // doubled quote is a literal quote
          mode_d         = cft_pkg::MODE_QUOTED;
          res_d.kind     = cft_pkg::KIND_DATA;
          res_d.char_out = cft_pkg::ChQuote;
        end else if (is_term) begin
          res_d.kind = cft_pkg::KIND_END;
          if (char_i == cft_pkg::ChNul) begin
            mode_d             = cft_pkg::MODE_DONE;
            res_d.ended_at_nul = 1'b1;
          end else begin
            mode_d = cft_pkg::MODE_START;
          end
        end else begin
          mode_d     = cft_pkg::MODE_DONE;
          res_d.kind = cft_pkg::KIND_ERROR;
        end
      end
      default: begin
        // done: swallow everything until the next line start
        mode_d = cft_pkg::MODE_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cft_pkg::MODE_START;
    end else if (step_i) begin
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

  a_mode_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("parser mode lost its one-hot code");

  a_error_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_d.kind == cft_pkg::KIND_ERROR) |=> mode_q == cft_pkg::MODE_DONE)
    else $error("error did not park the parser");

  a_done_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !line_begin_i && (mode_q == cft_pkg::MODE_DONE)
    |=> res_q.kind == cft_pkg::KIND_NONE)
    else $error("parser produced output after line end");

  a_nul_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && line_begin_i && (char_i == cft_pkg::ChNul)
    |=> (res_q.kind == cft_pkg::KIND_LINEEND) && (mode_q == cft_pkg::MODE_DONE))
    else $error("NUL at line start not reported as line end");

endmodule

/* rtl/csv_field_tokenizer.sv */
// Top level: streaming CSV field tokenizer, one character per beat.
//
//  channel  dir  tdata            tuser          tlast
//  s_axis   in   char_in[7:0]     line_begin     -
//  m_axis   out  char_out[7:0]    kind[2:0]      ended_at_nul
//
// Every input beat yields exactly one output beat, in order.
// Throughput is one beat per clock while the output is not stalled; beats
// pass the input register, then the parser decode's result register.
// Reset (rst_ni low, async) empties both registers and puts the parser at
// field start. Configuration: none.
// Output stall back-pressures through both stages; the input register
// still fills while the result register waits, and a stage advances
// whenever the stage after it is empty or is being drained.
module csv_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tuser_i,   // [0] line_begin
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] char_out
  output logic [2:0] m_axis_tuser_o,   // [2:0] kind
  output logic       m_axis_tlast_o    // ended_at_nul
);

  // Input register stage.
  logic                      in_vld_q, in_vld_d;
  logic [cft_pkg::CharW-1:0] in_char_q;
  logic                      in_lb_q;

  // Result stage valid.
  logic             out_vld_q, out_vld_d;
  logic             out_free;   // result register can take a new result
  logic             step;       // held character is decoded this cycle
  logic             in_take;
  cft_pkg::result_t res;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_take ? 1'b1 : (step ? 1'b0 : in_vld_q);
    if (step) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i;
      in_lb_q   <= s_axis_tuser_i;
    end
  end

  cft_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .char_i       (in_char_q),
    .line_begin_i (in_lb_q),
    .res_o        (res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = res.char_out;
  assign m_axis_tuser_o  = res.kind;
  assign m_axis_tlast_o  = res.ended_at_nul;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the streaming CSV field tokenizer.
module tb_top;
  import cft_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;

  // Input stream driven by the sender task
  logic       s_valid = 1'b0;
  logic [7:0] s_char = '0;
  logic       s_line_begin = 1'b0;
  logic       s_ready;

  // Output stream: ready driven by the sink process
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_char;
  logic [2:0] m_kind;
  logic       m_nul_end;

  // Parser state mirrored by the predictor
  mode_e      line_mode = MODE_START;
  result_t    pending_tokens[$];

  int         err_cnt = 0;
  int         chars_sent = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         at_line_start = 1'b1;
  bit         noise_on = 1'b0;

  // Long output stall request, counted down in the sink process
  int         hold_len = 0;
  int         hold_req = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  csv_field_tokenizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_char),
    .s_axis_tuser_i  (s_line_begin),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_char),
    .m_axis_tuser_o  (m_kind),
    .m_axis_tlast_o  (m_nul_end)
  );

  always #5 clk_i = ~clk_i;

  // Field ended by a terminator: NUL finishes the line, comma/newline opens the next field.
  function automatic void close_field(inout result_t r, input logic [7:0] c);
    r.kind         = KIND_END;
    r.ended_at_nul = (c == ChNul);
    line_mode      = (c == ChNul) ? MODE_DONE : MODE_START;
  endfunction

  function automatic result_t parse_char(input logic [7:0] c, input logic lb);
    result_t r;
    logic    term;
    r    = '{kind: KIND_NONE, char_out: '0, ended_at_nul: 1'b0};
    term = (c == ChComma) || (c == ChNl) || (c == ChNul);
    if (lb) line_mode = MODE_START;
    case (line_mode)
      MODE_START: begin
        if (c == ChNul) begin
          line_mode = MODE_DONE;
          r.kind    = KIND_LINEEND;
        end else if (c == ChQuote) begin
          line_mode = MODE_QUOTED;
        end else if (term) begin
          close_field(r, c);
        end else begin
          line_mode  = MODE_PLAIN;
          r.kind     = KIND_DATA;
          r.char_out = c;
        end
      end
      MODE_PLAIN: begin
        if (term) begin
          close_field(r, c);
        end else if (c == ChQuote) begin
          line_mode = MODE_DONE;
          r.kind    = KIND_ERROR;
        end else begin
          r.kind     = KIND_DATA;
          r.char_out = c;
        end
      end
      MODE_QUOTED: begin
        if (c == ChQuote) begin
          line_mode = MODE_QSEEN;
        end else if (c == ChNul) begin
          line_mode = MODE_DONE;
          r.kind    = KIND_ERROR;
        end else begin
          r.kind     = KIND_DATA;
          r.char_out = c;
        end
      end
      MODE_QSEEN: begin
        if (c == ChQuote) begin
          line_mode  = MODE_QUOTED;
          r.kind     = KIND_DATA;
          r.char_out = ChQuote;
        end else if (term) begin
          close_field(r, c);
        end else begin
          line_mode = MODE_DONE;
          r.kind    = KIND_ERROR;
        end
      end
      default: ;  // done: swallow everything until the next line start
    endcase
    return r;
  endfunction

  // Offer one beat; the prediction is queued once acceptance is certain.
  // Inputs only change at rising edges, so ready seen at the falling edge
  // is the value the next rising edge samples.
  task automatic send_char(input logic [7:0] c, input logic lb);
    logic ok;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid      <= 1'b1;
    s_char       <= c;
    s_line_begin <= lb;
    do begin
      @(negedge clk_i);
      ok = s_ready;
      if (ok) pending_tokens.push_back(parse_char(c, lb));
      @(posedge clk_i);
    end while (!ok);
    chars_sent++;
  endtask

  // Sender goes quiet until every expected beat has come back.
  task automatic drain;
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  // One character of a generated line, occasionally corrupted.
  task automatic put(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (noise_on && $urandom_range(99) < 3) v = 8'($urandom_range(255));
    send_char(v, at_line_start);
    at_line_start = 1'b0;
  endtask

  function automatic logic [7:0] plain_char;
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == ChComma || c == ChNl || c == ChQuote);
    return c;
  endfunction

  // Mostly well-formed lines with mixed quoted/unquoted fields; some pure noise.
  task automatic send_random_line;
    int nf;
    int len;
    int r;
    at_line_start = ($urandom_range(9) != 0);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 10)) begin
        send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
      return;
    end
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      len = $urandom_range(0, 6);
      if ($urandom_range(1)) begin
        put(ChQuote);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (r < 10) begin
            put(ChQuote);
            put(ChQuote);
          end else if (r < 20) put(ChComma);
          else if (r < 25) put(ChNl);
          else begin
            put(plain_char());
            if (r > 95) put(ChNul);  // NUL inside quotes
          end
        end
        put(ChQuote);
        if ($urandom_range(19) == 0) put(plain_char());  // junk after closing quote
      end else begin
        for (int k = 0; k < len; k++) put(plain_char());
        if ($urandom_range(29) == 0) put(ChQuote);  // quote in unquoted field
      end
      if (f == nf - 1) put(($urandom_range(9) != 0) ? ChNul : ChNl);
      else put($urandom_range(1) ? ChComma : ChNl);
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at  = chars_sent + count;
    noise_on = 1'b1;
    while (chars_sent < stop_at) send_random_line();
  endtask

  // Hand-picked sequence through every mode transition.
  task automatic test_directed;
    logic [8:0] script [27];
    script = '{
      {1'b1, 8'h61},   {1'b0, 8'hFF},   {1'b0, ChComma}, {1'b0, ChComma},
      {1'b0, ChNl},    {1'b0, ChQuote}, {1'b0, ChComma}, {1'b0, ChQuote},
      {1'b0, ChQuote}, {1'b0, ChQuote}, {1'b0, ChNl},    {1'b0, ChQuote},
      {1'b0, ChQuote}, {1'b0, ChNul},   {1'b0, 8'h78},   {1'b1, 8'h62},
      {1'b0, ChQuote}, {1'b1, 8'h80},   {1'b0, ChNul},   {1'b1, ChNul},
      {1'b1, ChQuote}, {1'b0, ChNul},   {1'b1, ChQuote}, {1'b0, ChQuote},
      {1'b0, 8'h7A},   {1'b1, 8'h01},   {1'b0, ChNl}
    };
    foreach (script[i]) send_char(script[i][7:0], script[i][8]);
    drain();
  endtask

  // Output held off long enough for the pipeline to fill and push back.
  task automatic test_output_stall;
    hold_len = 200;
    hold_req++;
    noise_on = 1'b0;
    repeat (4) send_random_line();
    drain();
  endtask

  // Sender waits for every result between two lines.
  task automatic test_sender_pause;
    noise_on = 1'b0;
    send_random_line();
    drain();
    send_random_line();
    drain();
  endtask

  task automatic test_random_phases;
    tx_idle_pct = 10;
    rx_idle_pct = 45;
    run_random(390);
    drain();
    tx_idle_pct = 45;
    rx_idle_pct = 10;
    run_random(390);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(390);
    drain();
  endtask

  // Sink: random ready, or a forced stall when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted output beat with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected output beat: kind %0d char %0h", m_kind, m_char);
        err_cnt++;
      end else begin
        want = pending_tokens.pop_front();
        if (m_kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_kind);
          err_cnt++;
        end
        if (m_char !== want.char_out) begin
          $error("char_out: expected %0h, got %0h", want.char_out, m_char);
          err_cnt++;
        end
        if (m_nul_end !== want.ended_at_nul) begin
          $error("ended_at_nul: expected %0b, got %0b", want.ended_at_nul, m_nul_end);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_sender_pause();
    test_random_phases();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending_tokens.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (pending_tokens.size() != 0) $error("%0d results never arrived", pending_tokens.size());
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
